[design/kdq_pkg.sv]
// Shared types, sizes and codes for the keyed doubly linked deque.
// No dependencies; every other design file imports this package.
package kdq_pkg;

  localparam int CAPACITY    = 64;
  localparam int STORE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int OP_W        = 3;
  localparam int STAT_W      = 2;
  localparam int GRP_W       = 8;
  localparam int GRP_IDX_W   = SLOT_W - $clog2(GRP_W);

  // Request opcodes
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  // Read address and write ports toward the link store
  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              key_we;
    logic [SLOT_W-1:0] key_wa;
    logic [KEY_W-1:0]  key_wd;
    logic              next_we;
    logic [SLOT_W-1:0] next_wa;
    logic [SLOT_W-1:0] next_wd;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_wa;
    logic [SLOT_W-1:0] prev_wd;
  } mem_req_t;

  // Registered read data of one slot
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] next;
    logic [SLOT_W-1:0] prev;
  } mem_rsp_t;

  // One result transaction
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic              is_dump;
    logic [KEY_W-1:0]  entry_key;
    logic              last;
  } result_t;

endpackage

[design/kdq_link_mem.sv]
// Slot store of the deque: key, next link and prev link arrays.
// One write port per array, one shared read address with registered read data. Uses kdq_pkg.
module kdq_link_mem (
  input  logic              clk,
  input  kdq_pkg::mem_req_t req,
  output kdq_pkg::mem_rsp_t rsp
);
  import kdq_pkg::*;

  logic [KEY_W-1:0]  key_mem  [STORE_DEPTH];
  logic [SLOT_W-1:0] next_mem [STORE_DEPTH];
  logic [SLOT_W-1:0] prev_mem [STORE_DEPTH];

  // Write each array on its own port
  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.key_wa] <= req.key_wd;
    end
    if (req.next_we) begin
      next_mem[req.next_wa] <= req.next_wd;
    end
    if (req.prev_we) begin
      prev_mem[req.prev_wa] <= req.prev_wd;
    end
  end

  // Read all three fields of one slot, registered
  always_ff @(posedge clk) begin
    rsp.key  <= key_mem[req.rd_addr];
    rsp.next <= next_mem[req.rd_addr];
    rsp.prev <= prev_mem[req.rd_addr];
  end

endmodule

[design/kdq_ctrl.sv]
// Sequencer of the deque: list head/tail/count, slot occupancy, free-slot scan,
// and the link walk that shares one key comparator. Uses kdq_pkg.
module kdq_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kdq_pkg::OP_W-1:0]   in_opcode,
  input  logic [kdq_pkg::KEY_W-1:0]  in_key,
  output logic                       busy,
  output kdq_pkg::mem_req_t          mem_req,
  input  kdq_pkg::mem_rsp_t          mem_rsp,
  output kdq_pkg::result_t           res
);
  import kdq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_INS_LINK = 5'b00100,
    ST_WALK     = 5'b01000,
    ST_UNLINK   = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [SLOT_W-1:0]      front_r, front_nxt;
  logic [SLOT_W-1:0]      back_r, back_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [STORE_DEPTH-1:0] used_r, used_nxt;
  logic [GRP_IDX_W-1:0]   grp_r, grp_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;

  logic [GRP_W-1:0]       grp_bits;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_slot;
  logic                   at_back;
  logic                   key_hit;
  logic                   do_unlink;

  // Lowest clear bit of one occupancy group
  function automatic logic [SLOT_W-GRP_IDX_W-1:0] first_zero(input logic [GRP_W-1:0] bits);
    logic [SLOT_W-GRP_IDX_W-1:0] idx;
    idx = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        idx = (SLOT_W-GRP_IDX_W)'(i);
      end
    end
    return idx;
  endfunction

  assign grp_bits   = used_r[{grp_r, {(SLOT_W-GRP_IDX_W){1'b0}}} +: GRP_W];
  assign free_found = ~&grp_bits;
  assign free_slot  = {grp_r, first_zero(grp_bits)};
  assign at_back    = ((pos_r + CNT_W'(1)) == count_r);
  assign key_hit    = (mem_rsp.key == key_r);
  assign busy       = (state_r != ST_IDLE);

  // Sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    grp_nxt   = grp_r;
    slot_nxt  = slot_r;
    do_unlink = 1'b0;

    mem_req         = '0;
    mem_req.rd_addr = cur_r;

    res           = '0;
    res.status    = STAT_OK;
    res.last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_opcode;
          key_nxt = in_key;
          pos_nxt = '0;
          case (in_opcode)
            OP_INSERT: begin
              if (count_r < CNT_W'(CAPACITY)) begin
                grp_nxt   = '0;
                state_nxt = ST_SCAN;
              end else begin
                res.valid  = 1'b1;
                res.status = STAT_FULL;
              end
            end
            OP_DEL_KEY, OP_DUMP: begin
              if (count_r == '0) begin
                res.valid  = 1'b1;
                res.status = (in_opcode == OP_DUMP) ? STAT_EMPTY : STAT_NOT_FOUND;
              end else begin
                mem_req.rd_addr = front_r;
                cur_nxt         = front_r;
                state_nxt       = ST_WALK;
              end
            end
            OP_DEL_FIRST: begin
              if (count_r == '0) begin
                res.valid  = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                mem_req.rd_addr = front_r;
                cur_nxt         = front_r;
                state_nxt       = ST_UNLINK;
              end
            end
            OP_DEL_LAST: begin
              if (count_r == '0) begin
                res.valid  = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                mem_req.rd_addr = back_r;
                cur_nxt         = back_r;
                pos_nxt         = count_r - CNT_W'(1);
                state_nxt       = ST_UNLINK;
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end

      // Look for the lowest free slot, one group a cycle, and fill it
      ST_SCAN: begin
        if (free_found) begin
          mem_req.key_we  = 1'b1;
          mem_req.key_wa  = free_slot;
          mem_req.key_wd  = key_r;
          mem_req.prev_we = 1'b1;
          mem_req.prev_wa = free_slot;
          mem_req.prev_wd = '0;
          mem_req.next_we = 1'b1;
          mem_req.next_wa = free_slot;
          used_nxt[free_slot] = 1'b1;
          slot_nxt = free_slot;
          if (count_r == '0) begin
            mem_req.next_wd = '0;
            back_nxt  = free_slot;
            front_nxt = free_slot;
            count_nxt = count_r + CNT_W'(1);
            res.valid = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            mem_req.next_wd = front_r;
            state_nxt       = ST_INS_LINK;
          end
        end else begin
          grp_nxt = grp_r + GRP_IDX_W'(1);
        end
      end

      // Point the old front back at the new slot
      ST_INS_LINK: begin
        mem_req.prev_we = 1'b1;
        mem_req.prev_wa = front_r;
        mem_req.prev_wd = slot_r;
        front_nxt = slot_r;
        count_nxt = count_r + CNT_W'(1);
        res.valid = 1'b1;
        state_nxt = ST_IDLE;
      end

      // Follow next links, one slot a cycle
      ST_WALK: begin
        if (op_r == OP_DUMP) begin
          res.valid     = 1'b1;
          res.is_dump   = 1'b1;
          res.entry_key = mem_rsp.key;
          res.last      = at_back;
        end
        if (op_r == OP_DEL_KEY && key_hit) begin
          do_unlink = 1'b1;
          res.valid = 1'b1;
          state_nxt = ST_IDLE;
        end else if (at_back) begin
          if (op_r != OP_DUMP) begin
            res.valid  = 1'b1;
            res.status = STAT_NOT_FOUND;
          end
          state_nxt = ST_IDLE;
        end else begin
          mem_req.rd_addr = mem_rsp.next;
          cur_nxt         = mem_rsp.next;
          pos_nxt         = pos_r + CNT_W'(1);
        end
      end

      // Drop an end slot once its links are read
      ST_UNLINK: begin
        do_unlink = 1'b1;
        res.valid = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Unlink cur_r at position pos_r
    if (do_unlink) begin
      if (pos_r == '0) begin
        front_nxt = mem_rsp.next;
      end else begin
        mem_req.next_we = 1'b1;
        mem_req.next_wa = mem_rsp.prev;
        mem_req.next_wd = mem_rsp.next;
      end
      if (at_back) begin
        back_nxt = mem_rsp.prev;
      end else begin
        mem_req.prev_we = 1'b1;
        mem_req.prev_wa = mem_rsp.next;
        mem_req.prev_wd = mem_rsp.prev;
      end
      used_nxt[cur_r] = 1'b0;
      count_nxt       = count_r - CNT_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
      used_r  <= used_nxt;
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    cur_r  <= cur_nxt;
    pos_r  <= pos_nxt;
    grp_r  <= grp_nxt;
    slot_r <= slot_nxt;
  end

endmodule

[design/keyed_doubly_linked_deque_unit.sv]
// Top level of the keyed doubly linked deque: sequencer, slot store and
// result register. Depends on kdq_pkg, kdq_link_mem and kdq_ctrl.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+------------------------
//   request  | in_opcode, in_key                            | start & !busy
//   result   | out_status, out_is_dump, out_entry_key,      | out_valid, one cycle
//            | out_last                                     |
//
// Requests that fail at once (full, empty, unused opcode) are answered without leaving idle;
// an end removal reads its slot, then unlinks it; an insert scans one 8-slot group per cycle
// for a free slot; a delete by key or a dump walks the list, one slot read per cycle
// through the registered store port; results are registered and show in the cycle after.
// rst_n is synchronous; it empties the list without touching the slot store.
// The receiver cannot stall: each result is presented for exactly one cycle.
module keyed_doubly_linked_deque_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [kdq_pkg::OP_W-1:0]           in_opcode,
  input  logic [kdq_pkg::KEY_W-1:0]          in_key,
  output logic                               out_valid,
  output logic [kdq_pkg::STAT_W-1:0]         out_status,
  output logic                               out_is_dump,
  output logic [kdq_pkg::KEY_W-1:0]          out_entry_key,
  output logic                               out_last
);
  import kdq_pkg::*;

  mem_req_t         mem_req;
  mem_rsp_t         mem_rsp;
  result_t          res;

  logic             valid_r;
  logic [STAT_W-1:0] status_r;
  logic             is_dump_r;
  logic [KEY_W-1:0] entry_key_r;
  logic             last_r;

  kdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .busy      (busy),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp),
    .res       (res)
  );

  kdq_link_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= res.valid;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    status_r    <= res.status;
    is_dump_r   <= res.is_dump;
    entry_key_r <= res.entry_key;
    last_r      <= res.last;
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_is_dump   = is_dump_r;
  assign out_entry_key = entry_key_r;
  assign out_last      = last_r;

endmodule
